/* hw/rtl/ccrl_pkg.sv */
// Shared types and constants for the chance-constrained region locator.
// No dependencies; every other file of the block imports this package.
package ccrl_pkg;

	// Table geometry: regions and half-space rows per region.
	localparam int MAX_REGIONS     = 8;
	localparam int ROWS_PER_REGION = 6;

	localparam int COEF_W     = 16;
	localparam int OFF_W      = 32;
	localparam int POS_W      = 32;
	localparam int VAR_W      = 32;
	localparam int MS_W       = 16;
	localparam int RC_W       = 4;
	localparam int ID_W       = 4;
	localparam int ADDR_W     = 6;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int K2_W       = 2 * MS_W;
	// Slack value offset*2^12 - a.x fits in 48 bits plus sign.
	localparam int D_W        = 51;

	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_SCALE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 4'd1;

	localparam logic [MS_W-1:0] MARGIN_RESET = 16'd4096;
	localparam logic [RC_W-1:0] COUNT_RESET  = 4'd0;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_LOCATE = 1'b1;

	// One stored half-space row.
	typedef struct packed {
		logic signed [COEF_W-1:0] coef_x;
		logic signed [COEF_W-1:0] coef_y;
		logic signed [COEF_W-1:0] coef_z;
		logic signed [OFF_W-1:0]  row_offset;
	} row_t;

	// Bookkeeping that travels with a row through the evaluation pipeline.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} row_tag_t;

	// Verdict leaving the pipeline, plus a busy flag for the sequencer.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic pass;
		logic busy;
	} pipe_out_t;

endpackage

/* hw/rtl/chance_constrained_region_locator_top.sv */
// Top level of the chance-constrained region locator: sequencer, registers,
// output slot. Depends on ccrl_pkg, ccrl_table and ccrl_row_pipe.
//
//   channel  direction  handshake            payload
//   in       in         in_valid/in_ready    cmd, row_address, coef_*, row_offset,
//                                            pos_*, var_*
//   out      out        out_valid/out_ready  region_id
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load, or a query with no region enabled, passes through the transfer, then the slot.
// A query walks N = min(region_count, MAX_REGIONS) > 0 regions:
// one table read per cycle into a six-stage row pipeline, its drain, the slot.
// Reset restores margin_scale 4096 and region_count 0 and holds both readies low;
// the table is not cleared.
// The result sits in an output register, so a new item is taken while it waits;
// a finished item stalls only when that register is still full.
module chance_constrained_region_locator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 cmd,
	input  logic [ccrl_pkg::ADDR_W-1:0]          row_address,
	input  logic signed [ccrl_pkg::COEF_W-1:0]   coef_x,
	input  logic signed [ccrl_pkg::COEF_W-1:0]   coef_y,
	input  logic signed [ccrl_pkg::COEF_W-1:0]   coef_z,
	input  logic signed [ccrl_pkg::OFF_W-1:0]    row_offset,
	input  logic signed [ccrl_pkg::POS_W-1:0]    pos_x,
	input  logic signed [ccrl_pkg::POS_W-1:0]    pos_y,
	input  logic signed [ccrl_pkg::POS_W-1:0]    pos_z,
	input  logic [ccrl_pkg::VAR_W-1:0]           var_x,
	input  logic [ccrl_pkg::VAR_W-1:0]           var_y,
	input  logic [ccrl_pkg::VAR_W-1:0]           var_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [ccrl_pkg::ID_W-1:0]            region_id,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ccrl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ccrl_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ccrl_pkg::*;

	localparam int TABLE_ROWS = MAX_REGIONS * ROWS_PER_REGION;
	localparam int AW  = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
	localparam int RW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int PW  = (ROWS_PER_REGION > 1) ? $clog2(ROWS_PER_REGION) : 1;
	localparam int RIW = $clog2(MAX_REGIONS + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0] state_q;
	logic live_q;

	logic [MS_W-1:0] margin_scale_q;
	logic [RC_W-1:0] region_count_q;
	logic [K2_W-1:0] k2_q;

	logic signed [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [VAR_W-1:0] var_x_q, var_y_q, var_z_q;

	logic [AW-1:0] row_ptr_q;
	logic [PW-1:0] rin_q;
	logic [RW-1:0] reg_q;
	logic [RW-1:0] n_last_q;

	logic [RIW-1:0] ereg_q;
	logic all_ok_q;
	logic found_q;
	logic [ID_W-1:0] id_q;

	logic out_valid_q;
	logic [ID_W-1:0] region_id_q;

	logic in_xfer;
	logic can_put;
	logic issue;
	logic row_last;
	logic grp_last;
	logic ok_c;
	logic addr_ok;
	logic [31:0] waddr32;
	logic [31:0] n_c;
	logic [31:0] gid_c;

	logic wr_en;
	row_t wr_row;
	row_t rd_row;
	row_tag_t tag_s0;
	pipe_out_t pipe_o;

	// Keep both readies low until reset has been released
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else begin
			live_q <= 1'b1;
		end
	end

	assign in_ready  = live_q && (state_q == ST_IDLE);
	assign in_xfer   = in_valid & in_ready;
	assign cfg_ready = live_q;
	assign can_put   = !out_valid_q || out_ready;

	assign waddr32 = 32'(row_address);
	assign addr_ok = (waddr32 < 32'(TABLE_ROWS));
	assign wr_en   = in_xfer && (cmd == CMD_LOAD) && addr_ok;

	always_comb begin
		wr_row.coef_x     = coef_x;
		wr_row.coef_y     = coef_y;
		wr_row.coef_z     = coef_z;
		wr_row.row_offset = row_offset;
	end

	assign n_c = (32'(region_count_q) > 32'(MAX_REGIONS)) ? 32'(MAX_REGIONS)
	                                                      : 32'(region_count_q);

	assign issue    = (state_q == ST_ISSUE);
	assign row_last = (rin_q == PW'(ROWS_PER_REGION - 1));
	assign grp_last = (reg_q == n_last_q);

	always_comb begin
		tag_s0.valid = issue;
		tag_s0.first = (rin_q == '0);
		tag_s0.last  = row_last;
	end

	ccrl_table #(
		.DEPTH(TABLE_ROWS),
		.AW   (AW)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(waddr32[AW-1:0]),
		.wr_data(wr_row),
		.rd_en  (issue),
		.rd_addr(row_ptr_q),
		.rd_data(rd_row)
	);

	ccrl_row_pipe u_pipe (
		.clk   (clk),
		.arst_n(arst_n),
		.tag_i (tag_s0),
		.row_i (rd_row),
		.pos_x (pos_x_q),
		.pos_y (pos_y_q),
		.pos_z (pos_z_q),
		.var_x (var_x_q),
		.var_y (var_y_q),
		.var_z (var_z_q),
		.k2    (k2_q),
		.pipe_o(pipe_o)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_scale_q <= MARGIN_RESET;
			region_count_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MARGIN_SCALE: margin_scale_q <= cfg_data[MS_W-1:0];
				CFG_REGION_COUNT: region_count_q <= cfg_data[RC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		k2_q <= margin_scale_q * margin_scale_q;
	end

	// Hold the query operands for the whole walk
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pos_x_q <= pos_x;
			pos_y_q <= pos_y;
			pos_z_q <= pos_z;
			var_x_q <= var_x;
			var_y_q <= var_y;
			var_z_q <= var_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (cmd == CMD_LOAD || n_c == 32'd0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: begin
					if (row_last && grp_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pipe_o.busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (can_put) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Read address walk: row within region, region, flat table address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ptr_q <= '0;
			rin_q     <= '0;
			reg_q     <= '0;
			n_last_q  <= '0;
		end else if (in_xfer) begin
			row_ptr_q <= '0;
			rin_q     <= '0;
			reg_q     <= '0;
			n_last_q  <= RW'(n_c - 32'd1);
		end else if (issue) begin
			row_ptr_q <= row_ptr_q + AW'(1);
			if (row_last) begin
				rin_q <= '0;
				reg_q <= reg_q + RW'(1);
			end else begin
				rin_q <= rin_q + PW'(1);
			end
		end
	end

	// Fold row verdicts into region verdicts; keep the first passing region
	assign ok_c  = (pipe_o.first | all_ok_q) & pipe_o.pass;
	assign gid_c = 32'(ereg_q) + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ereg_q   <= '0;
			all_ok_q <= 1'b1;
			found_q  <= 1'b0;
			id_q     <= '0;
		end else if (in_xfer) begin
			ereg_q   <= '0;
			all_ok_q <= 1'b1;
			found_q  <= 1'b0;
			id_q     <= '0;
		end else if (pipe_o.valid) begin
			if (pipe_o.last) begin
				ereg_q   <= ereg_q + RIW'(1);
				all_ok_q <= 1'b1;
				if (ok_c && !found_q) begin
					found_q <= 1'b1;
					id_q    <= gid_c[ID_W-1:0];
				end
			end else begin
				all_ok_q <= ok_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && can_put) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && can_put) begin
			region_id_q <= id_q;
		end
	end

	assign out_valid = out_valid_q;
	assign region_id = region_id_q;

	// The result slot is loaded only after every issued row has left the pipeline
	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> !pipe_o.busy)
		else $error("result slot loaded with rows still in flight");

	// Row verdicts only arrive while a query is being walked or drained
	a_verdict_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_o.valid |-> (state_q == ST_ISSUE || state_q == ST_DRAIN))
		else $error("row verdict outside a query");

	// No table write while rows are being read for a query
	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !pipe_o.busy && !issue)
		else $error("table written during a query walk");

	// An accepted item always leaves the idle state on the next cycle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q != ST_IDLE))
		else $error("accepted item left the sequencer idle");

endmodule

/* hw/rtl/ccrl_table.sv */
// Half-space row store: one synchronous memory, one write and one read port.
// Read data is registered. Uses ccrl_pkg::row_t.
module ccrl_table #(
	parameter int DEPTH = 48,
	parameter int AW    = 6
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  ccrl_pkg::row_t     wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output ccrl_pkg::row_t     rd_data
);
	import ccrl_pkg::*;

	row_t mem [DEPTH];
	row_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/ccrl_row_pipe.sv */
// Six-stage evaluation pipeline: one row per cycle, exact chance-constraint test
// d >= 0 and d^2 * 256 >= k^2 * q, with d split into 25-bit and q into 32-bit halves. Uses ccrl_pkg.
module ccrl_row_pipe (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ccrl_pkg::row_tag_t               tag_i,
	input  ccrl_pkg::row_t                   row_i,
	input  logic signed [ccrl_pkg::POS_W-1:0] pos_x,
	input  logic signed [ccrl_pkg::POS_W-1:0] pos_y,
	input  logic signed [ccrl_pkg::POS_W-1:0] pos_z,
	input  logic [ccrl_pkg::VAR_W-1:0]       var_x,
	input  logic [ccrl_pkg::VAR_W-1:0]       var_y,
	input  logic [ccrl_pkg::VAR_W-1:0]       var_z,
	input  logic [ccrl_pkg::K2_W-1:0]        k2,
	output ccrl_pkg::pipe_out_t              pipe_o
);
	import ccrl_pkg::*;

	localparam int AP_W = COEF_W + POS_W;          // a*pos
	localparam int AA_W = 2 * COEF_W - 1;          // a*a, never above 2^30
	localparam int T_W  = AA_W + VAR_W;            // a^2 * var
	localparam int Q_W  = 64;
	localparam int HW   = (D_W - 1) / 2;           // half of the slack magnitude
	localparam int DP_W = 2 * HW;                  // one partial product of d^2
	localparam int D2_W = 2 * (D_W - 1);           // d^2
	localparam int KQ_W = K2_W + Q_W;              // k^2 * q
	localparam int QH_W = Q_W / 2;

	row_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;

	// Stage 1 products
	logic signed [AP_W-1:0] ap0_c, ap1_c, ap2_c;
	logic signed [2*COEF_W-1:0] aa0_c, aa1_c, aa2_c;
	logic signed [AP_W-1:0] ap0_s2, ap1_s2, ap2_s2;
	logic [AA_W-1:0] aa0_s2, aa1_s2, aa2_s2;
	logic signed [OFF_W-1:0] off_s2;

	// Stage 2 slack and weighted variances
	logic signed [D_W-1:0] d_c;
	logic [T_W-1:0] t0_c, t1_c, t2_c;
	logic signed [D_W-1:0] d_s3;
	logic [T_W-1:0] t0_s3, t1_s3, t2_s3;

	// Stage 3 variance sum and partial squares of the slack
	logic [Q_W-1:0] q_c;
	logic [HW-1:0] dlo_c, dhi_c;
	logic [DP_W-1:0] ll_c, lh_c, hh_c;
	logic [Q_W-1:0] q_s4;
	logic [DP_W-1:0] ll_s4, lh_s4, hh_s4;
	logic neg_s4;

	// Stage 4 d^2 and halves of k^2 * q
	logic [D2_W-1:0] d2_c;
	logic [K2_W+QH_W-1:0] kl_c, kh_c;
	logic [D2_W-1:0] d2_s5;
	logic [K2_W+QH_W-1:0] kl_s5, kh_s5;
	logic neg_s5;

	// Stage 5 k^2 * q
	logic [KQ_W-1:0] kq_c;
	logic [D2_W-1:0] d2_s6;
	logic [KQ_W-1:0] kq_s6;
	logic neg_s6;

	// Stage 6 compare
	logic [D2_W+7:0] lhs_c;
	logic [D2_W+7:0] rhs_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
		end else begin
			tag_s1 <= tag_i;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
		end
	end

	always_comb begin
		ap0_c = $signed(row_i.coef_x) * pos_x;
		ap1_c = $signed(row_i.coef_y) * pos_y;
		ap2_c = $signed(row_i.coef_z) * pos_z;
		aa0_c = $signed(row_i.coef_x) * $signed(row_i.coef_x);
		aa1_c = $signed(row_i.coef_y) * $signed(row_i.coef_y);
		aa2_c = $signed(row_i.coef_z) * $signed(row_i.coef_z);
	end

	always_ff @(posedge clk) begin
		ap0_s2 <= ap0_c;
		ap1_s2 <= ap1_c;
		ap2_s2 <= ap2_c;
		aa0_s2 <= aa0_c[AA_W-1:0];
		aa1_s2 <= aa1_c[AA_W-1:0];
		aa2_s2 <= aa2_c[AA_W-1:0];
		off_s2 <= row_i.row_offset;
	end

	always_comb begin
		d_c  = (D_W'(off_s2) <<< 12) - D_W'(ap0_s2) - D_W'(ap1_s2) - D_W'(ap2_s2);
		t0_c = aa0_s2 * var_x;
		t1_c = aa1_s2 * var_y;
		t2_c = aa2_s2 * var_z;
	end

	always_ff @(posedge clk) begin
		d_s3  <= d_c;
		t0_s3 <= t0_c;
		t1_s3 <= t1_c;
		t2_s3 <= t2_c;
	end

	always_comb begin
		q_c   = Q_W'(t0_s3) + Q_W'(t1_s3) + Q_W'(t2_s3);
		dlo_c = d_s3[HW-1:0];
		dhi_c = d_s3[2*HW-1:HW];
		ll_c  = dlo_c * dlo_c;
		lh_c  = dlo_c * dhi_c;
		hh_c  = dhi_c * dhi_c;
	end

	always_ff @(posedge clk) begin
		q_s4   <= q_c;
		ll_s4  <= ll_c;
		lh_s4  <= lh_c;
		hh_s4  <= hh_c;
		neg_s4 <= d_s3[D_W-1];
	end

	always_comb begin
		// Cross term counts twice: shift by one more than the half width.
		d2_c = (D2_W'(hh_s4) << (2 * HW)) + (D2_W'(lh_s4) << (HW + 1)) + D2_W'(ll_s4);
		kl_c = k2 * q_s4[QH_W-1:0];
		kh_c = k2 * q_s4[Q_W-1:QH_W];
	end

	always_ff @(posedge clk) begin
		d2_s5  <= d2_c;
		kl_s5  <= kl_c;
		kh_s5  <= kh_c;
		neg_s5 <= neg_s4;
	end

	assign kq_c = (KQ_W'(kh_s5) << QH_W) + KQ_W'(kl_s5);

	always_ff @(posedge clk) begin
		d2_s6  <= d2_s5;
		kq_s6  <= kq_c;
		neg_s6 <= neg_s5;
	end

	always_comb begin
		lhs_c = {d2_s6, 8'b0};
		rhs_c = (D2_W + 8)'(kq_s6);
	end

	always_comb begin
		pipe_o.valid = tag_s6.valid;
		pipe_o.first = tag_s6.first;
		pipe_o.last  = tag_s6.last;
		pipe_o.pass  = !neg_s6 && (lhs_c >= rhs_c);
		pipe_o.busy  = tag_s1.valid | tag_s2.valid | tag_s3.valid |
		               tag_s4.valid | tag_s5.valid | tag_s6.valid;
	end

endmodule

/* tb/chance_constrained_region_locator_top_tb.sv */
// Testbench for chance_constrained_region_locator_top: loads half-space rows, runs
// located queries under many margin and region-count settings, and checks each
// region_id against a local predictor. Depends on ccrl_pkg and the block's RTL only.
`timescale 1ns / 100ps

module chance_constrained_region_locator_top_tb;
	import ccrl_pkg::*;

	localparam int NUM_REGIONS   = MAX_REGIONS;
	localparam int REGION_ROWS   = ROWS_PER_REGION;
	localparam int TABLE_ROWS    = NUM_REGIONS * REGION_ROWS;
	localparam int RANDOM_ITEMS  = 1850;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = TABLE_ROWS + 16;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNMAPPED = CFG_REGION_COUNT + CFG_IDX_W'(1);

	typedef struct packed {
		logic                     cmd;
		logic [ADDR_W-1:0]        row_address;
		row_t                     row;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
		logic [VAR_W-1:0]         var_x;
		logic [VAR_W-1:0]         var_y;
		logic [VAR_W-1:0]         var_z;
	} locator_item_t;

	typedef enum int {DRAIN_FREE, DRAIN_JITTER, DRAIN_CHOKED} drain_mode_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     cmd = CMD_LOAD;
	logic [ADDR_W-1:0]        row_address = '0;
	logic signed [COEF_W-1:0] coef_x = '0;
	logic signed [COEF_W-1:0] coef_y = '0;
	logic signed [COEF_W-1:0] coef_z = '0;
	logic signed [OFF_W-1:0]  row_offset = '0;
	logic signed [POS_W-1:0]  pos_x = '0;
	logic signed [POS_W-1:0]  pos_y = '0;
	logic signed [POS_W-1:0]  pos_z = '0;
	logic [VAR_W-1:0]         var_x = '0;
	logic [VAR_W-1:0]         var_y = '0;
	logic [VAR_W-1:0]         var_z = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [ID_W-1:0]          region_id;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;

	// Predictor state
	row_t            stored_rows [TABLE_ROWS];
	logic [MS_W-1:0] model_margin = MARGIN_RESET;
	logic [RC_W-1:0] model_count = COUNT_RESET;
	longint          region_center [NUM_REGIONS][3];
	logic [ID_W-1:0] region_ids_due [$];

	int              fail_count = 0;
	int              burst_left = 0;
	drain_mode_t     ready_mode = DRAIN_FREE;
	int              mode_left = 0;
	int              stall_left = 0;
	logic [ID_W-1:0] id_due;

	chance_constrained_region_locator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.row_address(row_address),
		.coef_x(coef_x),
		.coef_y(coef_y),
		.coef_z(coef_z),
		.row_offset(row_offset),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.var_x(var_x),
		.var_y(var_y),
		.var_z(var_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.region_id(region_id),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Exact test: slack >= 0 and slack^2 * 256 >= k^2 * sum(a_i^2 v_i).
	function automatic bit row_clears(row_t row, locator_item_t it);
		longint          normal [3];
		longint          spot [3];
		logic [VAR_W-1:0] spread [3];
		longint          slack;
		longint          sq;
		logic [127:0]    need;
		logic [127:0]    have;
		normal[0] = longint'($signed(row.coef_x));
		normal[1] = longint'($signed(row.coef_y));
		normal[2] = longint'($signed(row.coef_z));
		spot[0] = longint'($signed(it.pos_x));
		spot[1] = longint'($signed(it.pos_y));
		spot[2] = longint'($signed(it.pos_z));
		spread[0] = it.var_x;
		spread[1] = it.var_y;
		spread[2] = it.var_z;
		slack = longint'($signed(row.row_offset)) * 4096;
		need = '0;
		for (int i = 0; i < 3; i++) begin
			slack -= normal[i] * spot[i];
			sq = normal[i] * normal[i];
			need += 128'(sq) * spread[i];
		end
		if (slack < 0)
			return 1'b0;
		have = (128'(slack) * 128'(slack)) << 8;
		need = need * model_margin * model_margin;
		return have >= need;
	endfunction

	// Apply one item to the predictor and return the region_id it should produce.
	function automatic logic [ID_W-1:0] region_for_item(locator_item_t it);
		int n;
		bit holds;
		if (it.cmd == CMD_LOAD) begin
			if (it.row_address < TABLE_ROWS)
				stored_rows[it.row_address] = it.row;
			return '0;
		end
		n = (model_count > NUM_REGIONS) ? NUM_REGIONS : model_count;
		for (int g = 0; g < n; g++) begin
			holds = 1'b1;
			for (int r = 0; r < REGION_ROWS; r++)
				if (!row_clears(stored_rows[g * REGION_ROWS + r], it))
					holds = 1'b0;
			if (holds)
				return ID_W'(g + 1);
		end
		return '0;
	endfunction

	function automatic locator_item_t noise_item(logic kind);
		locator_item_t it;
		it.cmd = kind;
		it.row_address = ADDR_W'($urandom);
		it.row.coef_x = COEF_W'($urandom);
		it.row.coef_y = COEF_W'($urandom);
		it.row.coef_z = COEF_W'($urandom);
		it.row.row_offset = $urandom;
		it.pos_x = $urandom;
		it.pos_y = $urandom;
		it.pos_z = $urandom;
		it.var_x = $urandom;
		it.var_y = $urandom;
		it.var_z = $urandom;
		return it;
	endfunction

	function automatic locator_item_t row_load(input logic [ADDR_W-1:0] addr,
			input logic signed [COEF_W-1:0] cx, cy, cz, input logic signed [OFF_W-1:0] off);
		locator_item_t it;
		it = noise_item(CMD_LOAD);
		it.row_address = addr;
		it.row.coef_x = cx;
		it.row.coef_y = cy;
		it.row.coef_z = cz;
		it.row.row_offset = off;
		return it;
	endfunction

	function automatic locator_item_t query_at(input logic signed [POS_W-1:0] px, py, pz,
			input logic [VAR_W-1:0] vx, vy, vz);
		locator_item_t it;
		it = noise_item(CMD_LOCATE);
		it.pos_x = px;
		it.pos_y = py;
		it.pos_z = pz;
		it.var_x = vx;
		it.var_y = vy;
		it.var_z = vz;
		return it;
	endfunction

	// Query close to the center of region g, mostly with small variances.
	function automatic locator_item_t near_query(int g);
		longint          spot [3];
		logic [VAR_W-1:0] spread [3];
		for (int i = 0; i < 3; i++) begin
			spot[i] = region_center[g][i];
			if ($urandom_range(0, 4) != 0)
				spot[i] += longint'($urandom_range(0, 2 << 16)) - (1 << 16);
			case ($urandom_range(0, 9))
				0: spread[i] = '0;
				1: spread[i] = $urandom;
				default: spread[i] = $urandom_range(0, 1 << 15);
			endcase
		end
		return query_at(POS_W'(spot[0]), POS_W'(spot[1]), POS_W'(spot[2]),
			spread[0], spread[1], spread[2]);
	endfunction

	// Drive one item, hold it until the transfer, then idle per the burst pattern.
	task automatic send_item(input locator_item_t it);
		in_valid <= 1'b1;
		cmd <= it.cmd;
		row_address <= it.row_address;
		coef_x <= it.row.coef_x;
		coef_y <= it.row.coef_y;
		coef_z <= it.row.coef_z;
		row_offset <= it.row.row_offset;
		pos_x <= it.pos_x;
		pos_y <= it.pos_y;
		pos_z <= it.pos_z;
		var_x <= it.var_x;
		var_y <= it.var_y;
		var_z <= it.var_z;
		do @(posedge clk); while (!in_ready);
		region_ids_due = {region_ids_due, region_for_item(it)};
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 3))
				@(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 5);
		end
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (index)
			CFG_MARGIN_SCALE: model_margin = data[MS_W-1:0];
			CFG_REGION_COUNT: model_count = data[RC_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (region_ids_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// New random center for region g and six rows that enclose it with random slack.
	task automatic build_region(int g);
		logic signed [COEF_W-1:0] normal [3];
		longint reach;
		for (int i = 0; i < 3; i++)
			region_center[g][i] = longint'($urandom_range(0, 100 << 16)) - (50 << 16);
		for (int r = 0; r < REGION_ROWS; r++) begin
			reach = 0;
			for (int i = 0; i < 3; i++) begin
				normal[i] = ($urandom_range(0, 9) == 0) ? COEF_W'($urandom)
					: COEF_W'($urandom_range(0, 12288) - 6144);
				reach += longint'(normal[i]) * region_center[g][i];
			end
			send_item(row_load(ADDR_W'(g * REGION_ROWS + r), normal[0], normal[1], normal[2],
				OFF_W'((reach >>> 12) + longint'($urandom_range(0, 4 << 16)))));
		end
	endtask

	// Zero regions enabled after reset: every query misses.
	task automatic test_empty_locate();
		send_item(query_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, '1));
		send_item(query_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0, '0, '0));
	endtask

	task automatic test_row_loads();
		// out-of-range addresses must not touch the table
		send_item(row_load(ADDR_W'(TABLE_ROWS), 16'h8000, 16'h8000, 16'h8000, 32'h8000_0000));
		send_item(row_load('1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF));
		// region 0: box of half-width 4 around the origin
		send_item(row_load(6'd0, 16'sd4096, 16'sd0, 16'sd0, 32'sd4 << 16));
		send_item(row_load(6'd1, -16'sd4096, 16'sd0, 16'sd0, 32'sd4 << 16));
		send_item(row_load(6'd2, 16'sd0, 16'sd4096, 16'sd0, 32'sd4 << 16));
		send_item(row_load(6'd3, 16'sd0, -16'sd4096, 16'sd0, 32'sd4 << 16));
		send_item(row_load(6'd4, 16'sd0, 16'sd0, 16'sd4096, 32'sd4 << 16));
		send_item(row_load(6'd5, 16'sd0, 16'sd0, -16'sd4096, 32'sd4 << 16));
		// region 1: extreme coefficients and offsets, plus a zero row that ties exactly
		send_item(row_load(6'd6, 16'h8000, 16'h8000, 16'h8000, 32'h7FFF_FFFF));
		send_item(row_load(6'd7, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF));
		send_item(row_load(6'd8, 16'sd0, 16'sd0, 16'sd0, 32'sd0));
		send_item(row_load(6'd9, 16'h7FFF, 16'h8000, 16'sd0, 32'h7FFF_FFFF));
		send_item(row_load(6'd10, 16'sd0, 16'sd0, 16'sd0, 32'sd1));
		send_item(row_load(6'd11, 16'sd4096, 16'sd4096, 16'sd4096, 32'h7FFF_FFFF));
	endtask

	task automatic test_margin_extremes();
		logic [MS_W-1:0] margins [3];
		margins = '{16'd0, 16'hFFFF, MARGIN_RESET};
		wait_idle();
		// upper data bits are dropped by the count register
		write_register(CFG_REGION_COUNT, {12'hA00, 4'd2});
		write_register(CFG_IDX_W'($urandom_range(CFG_FIRST_UNMAPPED, 2 ** CFG_IDX_W - 1)),
			16'h5A5A);
		foreach (margins[m]) begin
			wait_idle();
			write_register(CFG_MARGIN_SCALE, margins[m]);
			send_item(query_at('0, '0, '0, '0, '0, '0));
			send_item(query_at(32'sd1 << 16, 32'sd2 << 16, -(32'sd3 << 16),
				32'd1 << 16, 32'd1 << 16, 32'd1 << 16));
			send_item(query_at(32'sd10 << 16, '0, '0, '1, '1, '1));
		end
	endtask

	task automatic test_fill_table();
		for (int g = 0; g < NUM_REGIONS; g++)
			build_region(g);
	endtask

	// Counts above the region total must test every region and no more.
	task automatic test_count_clamp();
		int counts [2];
		counts = '{2 ** RC_W - 1, NUM_REGIONS + 1};
		foreach (counts[c]) begin
			wait_idle();
			write_register(CFG_MARGIN_SCALE, MARGIN_RESET);
			write_register(CFG_REGION_COUNT, {(CFG_DATA_W - RC_W)'($urandom), RC_W'(counts[c])});
			for (int g = NUM_REGIONS - 1; g >= 0; g--)
				send_item(near_query(g));
		end
	endtask

	task automatic test_random_traffic();
		locator_item_t   it;
		logic [MS_W-1:0] margin;
		logic [RC_W-1:0] count;
		int done;
		int phase_len;
		int pick;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			wait_idle();
			case ($urandom_range(0, 4))
				0: margin = '0;
				1: margin = '1;
				2: margin = MARGIN_RESET;
				default: margin = MS_W'($urandom_range(1024, 12288));
			endcase
			count = ($urandom_range(0, 9) < 7) ? RC_W'($urandom_range(1, NUM_REGIONS))
				: RC_W'($urandom);
			write_register(CFG_MARGIN_SCALE, margin);
			write_register(CFG_REGION_COUNT, {(CFG_DATA_W - RC_W)'($urandom), count});
			if ($urandom_range(0, 3) == 0)
				write_register(CFG_IDX_W'($urandom_range(CFG_FIRST_UNMAPPED,
					2 ** CFG_IDX_W - 1)), CFG_DATA_W'($urandom));
			phase_len = $urandom_range(80, 220);
			for (int i = 0; i < phase_len && done < RANDOM_ITEMS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					send_item(near_query($urandom_range(0, NUM_REGIONS - 1)));
					done++;
				end else if (pick < 75) begin
					build_region($urandom_range(0, NUM_REGIONS - 1));
					done += REGION_ROWS;
				end else if (pick < 85) begin
					// raw row: may break a region until it is rebuilt
					it = noise_item(CMD_LOAD);
					send_item(it);
					done++;
				end else begin
					send_item(noise_item(CMD_LOCATE));
					done++;
				end
			end
		end
	endtask

	// Result checker and output stall pattern
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (region_ids_due.size() == 0) begin
				$error("region_id: expected none, got %0d", region_id);
				fail_count++;
			end else begin
				id_due = region_ids_due.pop_front();
				if (region_id !== id_due) begin
					$error("region_id: expected %0d, got %0d", id_due, region_id);
					fail_count++;
				end
			end
		end
		if (mode_left == 0) begin
			ready_mode = drain_mode_t'($urandom_range(0, 2));
			mode_left = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			case (ready_mode)
				DRAIN_FREE:   stall_left = 0;
				DRAIN_JITTER: stall_left = $urandom_range(0, 2);
				default:      stall_left = $urandom_range(3, 12);
			endcase
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_locate();
		test_row_loads();
		test_margin_extremes();
		test_fill_table();
		test_count_clamp();
		test_random_traffic();
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
